### rtl/core/md5sh_pkg.sv
// Shared types, constants and round tables for the streaming MD5 hasher.
package md5sh_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam int unsigned WORD_COUNT = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_word;   // take the input beat into the byte staging register
        logic       push_byte;   // append one byte to the block
        logic [1:0] push_sel;    // 0 data, 1 pad marker, 2 zero, 3 length byte
        logic       comp_start;  // latch chain into working registers
        logic       comp_step;   // one compression step
        logic       comp_finish; // fold working registers into the chain
        logic       restart;     // return to initial values
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       block_full;  // the last push filled the block
        logic [5:0] fill_pos;
        logic [2:0] bytes_left;  // data bytes still staged
        logic [2:0] len_idx;
        logic [5:0] step_idx;
    } t_status;

    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_PAD  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_shift(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word index used by step i.
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

### rtl/core/md5sh_stream_if.sv
// Valid/ready channel interface used for the input and result beats.
interface md5sh_stream_if #(
    parameter int unsigned WIDTH = 1
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/md5sh_datapath.sv
// Byte packing, block memory, length counter and MD5 step unit.
module md5sh_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  md5sh_pkg::t_cmd i_cmd,
    input  logic [31:0]     i_data_word,
    input  logic [2:0]      i_byte_count,
    output md5sh_pkg::t_status o_status,
    output logic [127:0]    o_digest
);
    import md5sh_pkg::*;

    logic [31:0] r_stage;
    logic [2:0]  r_left;
    logic [5:0]  r_fill;
    logic [63:0] r_bitlen;
    logic [63:0] r_lenlatch;
    logic [2:0]  r_lidx;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_step;
    logic [31:0] r_mem [WORD_COUNT];
    logic [31:0] r_word;
    logic        r_full;
    logic [7:0]  push_val;
    logic [2:0]  clamp;
    logic [31:0] f_val, t_sum, t_rot;
    logic [4:0]  sh;

    assign clamp = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;

    always_comb begin
        unique case (i_cmd.push_sel)
            SEL_DATA: push_val = r_stage[7:0];
            SEL_PAD:  push_val = PAD_BYTE;
            SEL_ZERO: push_val = 8'h00;
            default:  push_val = r_lenlatch[8*r_lidx +: 8];
        endcase
    end

    // Block memory: bytes are packed into a word register and written a word at a time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_byte) begin
            r_word[8*r_fill[1:0] +: 8] <= push_val;
            if (r_fill[1:0] == 2'd3) begin
                r_mem[r_fill[5:2]] <= {push_val, r_word[23:0]};
            end
        end
    end

    // Registered read of the word the next step needs.
    logic [31:0] r_x;
    logic [5:0]  rd_step;
    assign rd_step = i_cmd.comp_start ? 6'd0 : (r_step + 6'd1);
    always_ff @(posedge i_clk) begin
        r_x <= r_mem[msg_index(rd_step)];
    end

    always_comb begin
        unique case (r_step[5:4])
            2'd0: f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1: f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2: f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
        sh    = round_shift(r_step);
        t_sum = r_a + f_val + round_k(r_step) + r_x;
        t_rot = (t_sum << sh) | (t_sum >> (6'd32 - {1'b0, sh}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_fill   <= '0;
            r_bitlen <= '0;
            r_left   <= '0;
            r_lidx   <= '0;
            r_full   <= 1'b0;
            r_step   <= '0;
            r_chain[0] <= INIT_A;
            r_chain[1] <= INIT_B;
            r_chain[2] <= INIT_C;
            r_chain[3] <= INIT_D;
        end else begin
            r_full <= 1'b0;
            if (i_cmd.load_word) begin
                r_stage  <= i_data_word;
                r_left   <= clamp;
                r_bitlen <= r_bitlen + {58'd0, clamp, 3'd0};
                r_lenlatch <= r_bitlen + {58'd0, clamp, 3'd0};
                r_lidx   <= '0;
            end
            if (i_cmd.push_byte) begin
                r_fill <= r_fill + 6'd1;
                r_full <= (r_fill == 6'd63);
                if (i_cmd.push_sel == SEL_DATA) begin
                    r_stage <= {8'h00, r_stage[31:8]};
                    r_left  <= r_left - 3'd1;
                end
                if (i_cmd.push_sel == SEL_LEN) begin
                    r_lidx <= r_lidx + 3'd1;
                end
            end
            if (i_cmd.comp_start) begin
                r_a <= r_chain[0];
                r_b <= r_chain[1];
                r_c <= r_chain[2];
                r_d <= r_chain[3];
                r_step <= '0;
            end else if (i_cmd.comp_step) begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + t_rot;
                r_step <= r_step + 6'd1;
            end
            if (i_cmd.comp_finish) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
        end
    end

    assign o_status = '{block_full: r_full, fill_pos: r_fill, bytes_left: r_left,
                        len_idx: r_lidx, step_idx: r_step};
    assign o_digest = {r_chain[3], r_chain[2], r_chain[1], r_chain[0]};

`ifndef SYNTHESIS
    a_fill_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_byte && !i_cmd.restart && r_fill == 6'd63) |=> (r_fill == 6'd0 && r_full))
        else $error("fill position did not wrap with a full block");
    a_step_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.comp_step && !i_cmd.comp_start && !i_cmd.restart) |=> r_step == $past(r_step) + 6'd1)
        else $error("step counter did not advance");
    a_no_push_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push_byte && i_cmd.comp_step))
        else $error("byte pushed during compression");
`endif
endmodule

### rtl/core/md5sh_ctrl.sv
// Sequencer for byte appending, padding, compression and digest output.
module md5sh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_out_half,
    input  md5sh_pkg::t_status i_status,
    output md5sh_pkg::t_cmd    o_cmd
);
    import md5sh_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DATA  = 9'b000000010,
        S_PAD   = 9'b000000100,
        S_ZERO  = 9'b000001000,
        S_LEN   = 9'b000010000,
        S_CPREP = 9'b000100000,
        S_COMP  = 9'b001000000,
        S_FOLD  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        R_DATA = 2'd0, R_PAD = 2'd1, R_ZERO = 2'd2, R_LEN = 2'd3
    } t_resume;

    t_state  r_state, n_state;
    t_resume r_resume, n_resume;
    logic    r_last, n_last;
    logic    r_half, n_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resume <= R_DATA;
            r_last   <= 1'b0;
            r_half   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
            r_last   <= n_last;
            r_half   <= n_half;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        n_last   = r_last;
        n_half   = r_half;
        o_cmd    = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_word = 1'b1;
                    n_last  = i_in_last;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (i_status.block_full) begin
                    n_resume = R_DATA;
                    n_state  = S_CPREP;
                end else if (i_status.bytes_left != 3'd0) begin
                    o_cmd.push_byte = 1'b1;
                    o_cmd.push_sel  = SEL_DATA;
                end else if (r_last) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.push_byte = 1'b1;
                o_cmd.push_sel  = SEL_PAD;
                n_state = S_ZERO;
            end
            S_ZERO: begin
                if (i_status.block_full) begin
                    n_resume = R_ZERO;
                    n_state  = S_CPREP;
                end else if (i_status.fill_pos == LEN_POS) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.push_byte = 1'b1;
                    o_cmd.push_sel  = SEL_ZERO;
                end
            end
            S_LEN: begin
                if (i_status.block_full) begin
                    n_resume = R_LEN;
                    n_state  = S_CPREP;
                end else begin
                    o_cmd.push_byte = 1'b1;
                    o_cmd.push_sel  = SEL_LEN;
                end
            end
            S_CPREP: begin
                o_cmd.comp_start = 1'b1;
                n_state = S_COMP;
            end
            S_COMP: begin
                o_cmd.comp_step = 1'b1;
                if (i_status.step_idx == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.comp_finish = 1'b1;
                unique case (r_resume)
                    R_DATA:  n_state = S_DATA;
                    R_PAD:   n_state = S_PAD;
                    R_ZERO:  n_state = S_ZERO;
                    default: n_state = S_OUT;
                endcase
                n_half = 1'b0;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_half = ~r_half;
                    if (r_half) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_half = r_half;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state register not one-hot");
    a_out_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while digest pending");
    a_len_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD && r_resume == R_LEN) |=> r_state == S_OUT)
        else $error("final block did not lead to digest output");
`endif
endmodule

### rtl/core/md5_stream_hasher.sv
// Top level of the streaming MD5 hasher.
//
//  channel  dir  payload                                         handshake
//  i_in     in   data_word[31:0] byte_count[2:0] end_of_message  valid/ready
//  o_out    out  digest_half[63:0] half_index last_of_run        valid/ready
//
// An input beat is taken in the idle state, then its bytes enter the block one
// per cycle while no full block is being compressed, and the controller returns
// to idle; only there is the next beat accepted. For each full block the full
// block is seen, the working registers are loaded, the single shared step unit
// runs 64 steps, and the result is folded into the chain. At end of message
// the padding goes in a byte per cycle while no full block is compressed, then
// the two digest halves wait in the output state; a stall there holds them.
// Reset is synchronous and active low and returns the chain to the MD5
// initial values with an empty block.
module md5_stream_hasher (
    input  logic           i_clk,
    input  logic           i_rst_n,
    md5sh_stream_if.sink   i_in,
    md5sh_stream_if.source o_out
);
    import md5sh_pkg::*;

    t_cmd         cmd;
    t_status      status;
    logic [127:0] digest;
    logic         out_half;

    // Input payload: {end_of_message, byte_count, data_word}.
    md5sh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.data[35]),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_half  (out_half),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    md5sh_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_word  (i_in.data[31:0]),
        .i_byte_count (i_in.data[34:32]),
        .o_status     (status),
        .o_digest     (digest)
    );

    // Output payload: {last_of_run, half_index, digest_half}.
    assign o_out.data = {out_half, out_half, out_half ? digest[127:64] : digest[63:0]};

`ifndef SYNTHESIS
    a_last_is_half1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !out_half) |=> (o_out.valid && out_half))
        else $error("second digest half did not follow the first");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(o_out.data))
        else $error("digest changed while stalled");
    a_in_blocked_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second beat accepted while bytes pending");
`endif
endmodule

### tb/tb_top.sv
// Self-checking testbench for the streaming MD5 hasher, with an MD5 predictor of its own.
`timescale 1ns / 1ps
module tb_top;
    import md5sh_pkg::*;

    localparam int unsigned IN_W  = 36;
    localparam int unsigned OUT_W = 66;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_START = 3000;
    localparam int unsigned HOLD_LEN   = 500;
    localparam int unsigned CALM_START = 5000;
    localparam int unsigned CALM_END   = 7000;
    localparam int unsigned IDLE_PCT   = 27;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        eom;
        logic        drain_first; // wait for every digest before offering this beat
    } t_beat;

    // Same bit order as the output payload: {last_of_run, half_index, digest_half}.
    typedef struct packed {
        logic        last;
        logic        idx;
        logic [63:0] half;
    } t_digest_half;

    logic i_clk;
    logic i_rst_n;
    md5sh_stream_if #(.WIDTH(IN_W))  in_ch ();
    md5sh_stream_if #(.WIDTH(OUT_W)) out_ch ();

    md5_stream_hasher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Stimulus, expected digests and the predictor's own copy of the state.
    t_beat        beat_q[$];
    t_digest_half digest_q[$];
    logic [31:0]  chain[4];
    logic [63:0]  msg_bits;
    logic [7:0]   blk[64];
    logic [5:0]   fill;
    int unsigned  cyc;
    int unsigned  rx_cyc;
    int unsigned  errors;
    bit           offering;
    bit           calm;

    const logic [31:0] sine_k[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
        32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
        32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
        32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
        32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
        32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    const int unsigned rot_amt[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                       6, 10, 15, 21};

    function automatic logic [31:0] rotl(logic [31:0] x, int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // Runs the 64 rounds over the current block and folds them into the chain.
    function void compress_block();
        logic [31:0] m[16];
        logic [31:0] a, b, c, d, f, t;
        int unsigned g;
        for (int w = 0; w < 16; w++)
            m[w] = {blk[4*w+3], blk[4*w+2], blk[4*w+1], blk[4*w]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (d & b) | (~d & c); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d;          g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            t = a + f + sine_k[r] + m[g];
            t = b + rotl(t, rot_amt[(r / 16) * 4 + r % 4]);
            a = d; d = c; c = b; b = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function void append_byte(logic [7:0] v);
        blk[fill] = v;
        fill = fill + 6'd1;
        if (fill == 6'd0)
            compress_block();
    endfunction

    function void restart_hash();
        chain[0] = INIT_A; chain[1] = INIT_B; chain[2] = INIT_C; chain[3] = INIT_D;
        msg_bits = '0;
        fill = '0;
    endfunction

    // Appends one beat to the stimulus.
    function void queue_beat(logic [31:0] word, logic [2:0] nbytes, logic eom, logic drain);
        t_beat bt;
        bt.word = word;
        bt.nbytes = nbytes;
        bt.eom = eom;
        bt.drain_first = drain;
        beat_q = {beat_q, bt};
    endfunction

    // Appends one expected digest half.
    function void expect_half(logic [63:0] half, logic idx, logic last);
        t_digest_half h;
        h.half = half;
        h.idx = idx;
        h.last = last;
        digest_q = {digest_q, h};
    endfunction

    // Applies one accepted beat; at end of message it pads, queues both halves and restarts.
    function void hash_beat(logic [31:0] word, logic [2:0] nbytes, logic eom);
        int unsigned n;
        logic [63:0] len;
        n = (nbytes > 3'd4) ? 4 : nbytes;
        for (int k = 0; k < n; k++) begin
            append_byte(word[8*k +: 8]);
            msg_bits += 64'd8;
        end
        if (eom) begin
            len = msg_bits;
            append_byte(PAD_BYTE);
            while (fill != LEN_POS)
                append_byte(8'h00);
            for (int k = 0; k < 8; k++)
                append_byte(len[8*k +: 8]);
            expect_half({chain[1], chain[0]}, 1'b0, 1'b0);
            expect_half({chain[3], chain[2]}, 1'b1, 1'b1);
            restart_hash();
        end
    endfunction

    // Adds one message to the stimulus: nwords data beats, then a closing beat with the
    // end flag.
    function void add_message(int unsigned nwords, bit hold);
        logic [2:0] nb;
        logic       last;
        for (int w = 0; w <= nwords; w++) begin
            last = (w == nwords);
            if (last)
                nb = 3'($urandom_range(0, 4));
            else if ($urandom_range(0, 99) < 70)
                nb = 3'd4;
            else if ($urandom_range(0, 99) < 15)
                nb = 3'($urandom_range(5, 7));
            else
                nb = 3'($urandom_range(1, 3));
            queue_beat($urandom(), nb, last, hold && (w == 0));
            // Empty beats without the end flag are noise the block must ignore.
            if (!last && $urandom_range(0, 99) < 4)
                queue_beat($urandom(), 3'd0, 1'b0, 1'b0);
        end
    endfunction

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

    // Driver: a beat accepted at the rising edge is predicted at once; the next one is
    // put on the channel at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            hash_beat(in_ch.data[31:0], in_ch.data[34:32], in_ch.data[35]);
            offering = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        t_beat bt;
        if (i_rst_n && !offering) begin
            if (beat_q.size() == 0 || (beat_q[0].drain_first && digest_q.size() != 0)
                    || (!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
                in_ch.valid <= 1'b0;
            end else begin
                bt = beat_q.pop_front();
                in_ch.data  <= {bt.eom, bt.nbytes, bt.word};
                in_ch.valid <= 1'b1;
                offering = 1'b1;
            end
        end
    end

    // The receiver stalls at random, and once holds off long enough for the block to back up.
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: every digest half is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_digest_half got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (digest_q.size() == 0) begin
                $error("digest beat with nothing expected: %h", got);
                errors++;
            end else begin
                want = digest_q.pop_front();
                if (got.half !== want.half) begin
                    $error("digest_half: expected %h, got %h", want.half, got.half);
                    errors++;
                end
                if (got.idx !== want.idx) begin
                    $error("half_index: expected %0d, got %0d", want.idx, got.idx);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        bit hold;
        bit drained;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cyc = 0;
        rx_cyc = 0;
        errors = 0;
        offering = 1'b0;
        drained = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        restart_hash();

        // Directed part: the empty message, an ignored empty beat, a single byte,
        // byte counts above four, all-ones and all-zeros data, and a 56-byte message
        // whose padding spills into a second block.
        queue_beat(32'h0, 3'd0, 1'b1, 1'b0);
        queue_beat(32'hdeadbeef, 3'd0, 1'b0, 1'b0);
        queue_beat(32'h00000061, 3'd1, 1'b1, 1'b0);
        queue_beat(32'hffffffff, 3'd7, 1'b0, 1'b0);
        queue_beat(32'h00000000, 3'd5, 1'b0, 1'b0);
        queue_beat(32'ha5a5a5a5, 3'd6, 1'b1, 1'b0);
        for (int w = 0; w < 14; w++)
            queue_beat(32'hffffffff, 3'd4, 1'b0, 1'b0);
        queue_beat(32'h0, 3'd0, 1'b1, 1'b0);

        // Random messages, mostly short, a few spanning several blocks. One message
        // past the middle waits until every digest before it has come out.
        while (beat_q.size() < 900) begin
            hold = !drained && (beat_q.size() > 450);
            if (hold)
                drained = 1'b1;
            add_message(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 20),
                        hold);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beat_q.size() != 0 || offering || digest_q.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (errors == 0 && digest_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
